>>> hw/rtl/cfc_pkg.sv
package cfc_pkg;

  localparam int unsigned MaxFrameDef = 200;

  localparam logic [15:0] CrcInit  = 16'hFFFF;
  localparam logic [15:0] CrcPoly  = 16'hA001;
  localparam logic [7:0]  MinFrame = 8'd7;

  // byte positions inside a frame
  localparam logic [7:0] PosHeader  = 8'd0;
  localparam logic [7:0] PosAddress = 8'd1;
  localparam logic [7:0] PosCommand = 8'd2;
  localparam logic [7:0] PosLength  = 8'd3;

  typedef enum logic [1:0] {
    CFG_HEADER  = 2'd0,
    CFG_TRAILER = 2'd1,
    CFG_ADDRESS = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_IDLE = 1'b1
  } kind_e;

  typedef struct packed {
    logic [7:0] header_byte;
    logic [7:0] trailer_byte;
    logic [7:0] device_address;
  } cfg_t;

  // frame_good sits in the lowest bit
  typedef struct packed {
    logic [7:0] byte_total;
    logic [7:0] payload_length;
    logic [7:0] command_code;
    logic       frame_good;
  } result_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> hw/rtl/crc16_frame_checker_core.sv
// Frame checker for byte streams: header, address, command, length, payload,
// CRC-16/Modbus (low byte first) and trailer. Each slave transaction is either
// a received byte (tuser 0) or a line-idle event (tuser 1); an idle event yields
// one master transaction with the verdict and clears the frame state. One
// transaction is taken every cycle; an idle event waits in the input register
// while its verdict is formed from the frame state and loaded into the result
// register, which then offers it. The combinational eight-bit CRC update sets
// the rate. A stalled result holds up the input only once an idle event
// reaches the input register; received bytes flow past it.
module crc16_frame_checker_core #(
  parameter int unsigned MaxFrame = cfc_pkg::MaxFrameDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  input  logic [0:0]  s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // frame_good, command_code, payload_length,
                                      // byte_total, zero fill
);
  import cfc_pkg::*;

  cfg_t    cfg_q;
  logic    in_vld_q;
  kind_e   in_kind_q;
  logic [7:0] in_byte_q;
  logic    out_vld_q;
  result_t out_q;
  result_t result;
  logic    advance;

  assign advance = in_vld_q && ((in_kind_q == KIND_BYTE) || !out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HEADER:  cfg_q.header_byte    <= cfg_wdata_i;
        CFG_TRAILER: cfg_q.trailer_byte   <= cfg_wdata_i;
        CFG_ADDRESS: cfg_q.device_address <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_kind_q <= kind_e'(s_axis_tuser[0]);
      in_byte_q <= s_axis_tdata;
    end
  end

  cfc_frame_eval #(
    .MaxFrame(MaxFrame)
  ) u_eval (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .proc_en_i(advance),
    .kind_i   (in_kind_q),
    .rx_byte_i(in_byte_q),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance && (in_kind_q == KIND_IDLE)) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && (in_kind_q == KIND_IDLE)) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'b0, out_q};

endmodule

>>> hw/rtl/cfc_frame_eval.sv
module cfc_frame_eval #(
  parameter int unsigned MaxFrame = cfc_pkg::MaxFrameDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             proc_en_i,
  input  cfc_pkg::kind_e   kind_i,
  input  logic [7:0]       rx_byte_i,
  input  cfc_pkg::cfg_t    cfg_i,
  output cfc_pkg::result_t result_o
);
  import cfc_pkg::*;

  localparam logic [7:0] MaxCnt = 8'(MaxFrame);

  logic [7:0]  count_q, count_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  tail_q [3];
  logic [7:0]  tail_d [3];
  logic        head_ok_q, head_ok_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  cmd_q, cmd_d;
  logic        ovf_q, ovf_d;
  logic        good;

  always_comb begin
    good = !ovf_q
        && (count_q >= MinFrame)
        && head_ok_q
        && (len_q == 8'(count_q - MinFrame))
        && (tail_q[0] == cfg_i.trailer_byte)
        && (tail_q[1] == crc_q[15:8])
        && (tail_q[2] == crc_q[7:0]);
    result_o.frame_good     = good;
    result_o.command_code   = cmd_q;
    result_o.payload_length = len_q;
    result_o.byte_total     = count_q;
  end

  always_comb begin
    count_d   = count_q;
    crc_d     = crc_q;
    tail_d    = tail_q;
    head_ok_d = head_ok_q;
    len_d     = len_q;
    cmd_d     = cmd_q;
    ovf_d     = ovf_q;
    if (proc_en_i) begin
      if (kind_i == KIND_IDLE) begin
        count_d   = '0;
        crc_d     = CrcInit;
        tail_d    = '{default: '0};
        head_ok_d = 1'b0;
        len_d     = '0;
        cmd_d     = '0;
        ovf_d     = 1'b0;
      end else if (count_q >= MaxCnt) begin
        ovf_d = 1'b1;
      end else begin
        case (count_q)
          PosHeader:  head_ok_d = (rx_byte_i == cfg_i.header_byte);
          PosAddress: head_ok_d = head_ok_q && (rx_byte_i == cfg_i.device_address);
          PosCommand: cmd_d = rx_byte_i;
          PosLength:  len_d = rx_byte_i;
          default: ;
        endcase
        if (count_q >= PosLength) begin
          crc_d = crc16_byte(crc_q, tail_q[2]);
        end
        tail_d[2] = tail_q[1];
        tail_d[1] = tail_q[0];
        tail_d[0] = rx_byte_i;
        count_d   = count_q + 8'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      crc_q     <= CrcInit;
      tail_q    <= '{default: '0};
      head_ok_q <= 1'b0;
      len_q     <= '0;
      cmd_q     <= '0;
      ovf_q     <= 1'b0;
    end else begin
      count_q   <= count_d;
      crc_q     <= crc_d;
      tail_q    <= tail_d;
      head_ok_q <= head_ok_d;
      len_q     <= len_d;
      cmd_q     <= cmd_d;
      ovf_q     <= ovf_d;
    end
  end

endmodule

>>> hw/rtl/cfc_checker.sv
module cfc_checker #(
  parameter int unsigned MaxFrame = cfc_pkg::MaxFrameDef
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);
  import cfc_pkg::*;

  result_t res;
  assign res = result_t'(m_axis_tdata[24:0]);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result offered during reset");

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> res.byte_total <= 8'(MaxFrame))
    else $error("byte total above frame limit");

  a_good_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.frame_good |->
      res.byte_total >= MinFrame && res.payload_length == 8'(res.byte_total - MinFrame)
      && res.byte_total <= 8'(MaxFrame))
    else $error("good frame with inconsistent length");

endmodule

bind crc16_frame_checker_core cfc_checker #(
  .MaxFrame(MaxFrame)
) u_cfc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
